>>> sv/checksummed_packet_deframer_assert.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_PACKET_DEFRAMER_ASSERT_SVH
`define CHECKSUMMED_PACKET_DEFRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CPD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPD_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> sv/cpd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Types, codes and reset values shared by the deframer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpd_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'd147;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'd224;
  localparam logic [15:0] MAX_LENGTH_RST  = 16'd4096;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_FAIL    = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_SYNC2    = 3'd1,
    PH_ID       = 3'd2,
    PH_LEN_LO   = 3'd3,
    PH_LEN_HI   = 3'd4,
    PH_PAYLOAD  = 3'd5,
    PH_CHECK_LO = 3'd6,
    PH_CHECK_HI = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [7:0]  msg_id;
    logic [15:0] packet_length;
  } result_t;

endpackage

>>> sv/cpd_if.sv
// ----------------------------------------------------------------------------
// Deframer stream interfaces
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cpd_res_if;
  logic                valid;
  logic                ready;
  cpd_pkg::kind_t      kind;
  logic [7:0]          payload_byte;
  logic [15:0]         byte_index;
  logic [7:0]          msg_id;
  logic [15:0]         packet_length;

  modport source (output valid, output kind, output payload_byte, output byte_index,
                  output msg_id, output packet_length, input ready);
  modport sink   (input valid, input kind, input payload_byte, input byte_index,
                  input msg_id, input packet_length, output ready);
endinterface

>>> sv/cpd_parser.sv
// ----------------------------------------------------------------------------
// Deframer parser
// Phase machine, frame fields and Fletcher sums; one byte per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  cpd_pkg::cfg_t    cfg,
  output cpd_pkg::result_t result
);
  import cpd_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  check_low, check_low_next;

  logic [7:0]  acc_a, acc_b;
  logic [7:0]  base_a, base_b;
  logic [15:0] len_new;
  logic [15:0] count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_id     <= '0;
      frame_length <= '0;
      byte_count   <= '0;
      sum_a        <= '0;
      sum_b        <= '0;
      check_low    <= '0;
    end else if (step) begin
      phase        <= phase_next;
      frame_id     <= frame_id_next;
      frame_length <= frame_length_next;
      byte_count   <= byte_count_next;
      sum_a        <= sum_a_next;
      sum_b        <= sum_b_next;
      check_low    <= check_low_next;
    end
  end

  // sums restart on the id byte
  assign base_a    = (phase == PH_ID) ? 8'd0 : sum_a;
  assign base_b    = (phase == PH_ID) ? 8'd0 : sum_b;
  assign acc_a     = base_a + rx_byte;
  assign acc_b     = base_b + acc_a;
  assign len_new   = {rx_byte, frame_length[7:0]};
  assign count_inc = byte_count + 16'd1;

  always_comb begin
    phase_next        = phase;
    frame_id_next     = frame_id;
    frame_length_next = frame_length;
    byte_count_next   = byte_count;
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    check_low_next    = check_low;
    result.valid        = 1'b0;
    result.kind         = KIND_PAYLOAD;
    result.payload_byte = '0;
    result.byte_index   = '0;

    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == cfg.sync_first) phase_next = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (rx_byte == cfg.sync_second) phase_next = PH_ID;
        else if (rx_byte != cfg.sync_first) phase_next = PH_HUNT;
      end
      PH_ID: begin
        frame_id_next = rx_byte;
        sum_a_next    = acc_a;
        sum_b_next    = acc_b;
        phase_next    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_length_next = {8'd0, rx_byte};
        sum_a_next        = acc_a;
        sum_b_next        = acc_b;
        phase_next        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_length_next = len_new;
        sum_a_next        = acc_a;
        sum_b_next        = acc_b;
        byte_count_next   = '0;
        if (len_new > cfg.max_length) begin
          result.valid = 1'b1;
          result.kind  = KIND_REJECT;
          phase_next   = PH_HUNT;
        end else if (len_new == 16'd0) begin
          phase_next = PH_CHECK_LO;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        result.valid        = 1'b1;
        result.kind         = KIND_PAYLOAD;
        result.payload_byte = rx_byte;
        result.byte_index   = byte_count;
        sum_a_next          = acc_a;
        sum_b_next          = acc_b;
        byte_count_next     = count_inc;
        if (count_inc >= frame_length) phase_next = PH_CHECK_LO;
      end
      PH_CHECK_LO: begin
        check_low_next = rx_byte;
        phase_next     = PH_CHECK_HI;
      end
      PH_CHECK_HI: begin
        result.valid = 1'b1;
        result.kind  = (check_low == sum_a && rx_byte == sum_b) ? KIND_ACCEPT : KIND_FAIL;
        phase_next   = PH_HUNT;
      end
      default: phase_next = PH_HUNT;
    endcase

    result.msg_id        = frame_id_next;
    result.packet_length = frame_length_next;
  end

endmodule

>>> sv/checksummed_packet_deframer.sv
// ----------------------------------------------------------------------------
// Checksummed packet deframer
// Sync/id/length framing with a Fletcher-style trailer check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Takes one received byte per clock and gives at most one result per byte:
// each payload byte with its index, then an accept or fail result at the
// second trailer byte, or a reject result at the length high byte when the
// length exceeds max_length. A byte is parsed in the cycle of its transfer
// and its result sits in the output register from the next cycle, so the
// sustained rate is one byte per cycle; rx.ready drops only while a result
// is held in that register and the sink is not taking it. Registers take
// effect at the write edge and must be written with the block idle.
module checksummed_packet_deframer (
  input  logic                            clk,
  input  logic                            rst,
  cpd_rx_if.sink                          rx,
  cpd_res_if.source                       res,
  input  logic                            cfg_we,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cpd_pkg::*;

  `include "checksummed_packet_deframer_assert.svh"

  cfg_t    cfg;
  result_t step_res;
  logic    step;

  logic        out_valid;
  kind_t       out_kind;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_byte_index;
  logic [7:0]  out_msg_id;
  logic [15:0] out_packet_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= SYNC_FIRST_RST;
      cfg.sync_second <= SYNC_SECOND_RST;
      cfg.max_length  <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  cfg.sync_first  <= cfg_data[7:0];
        CFG_SYNC_SECOND: cfg.sync_second <= cfg_data[7:0];
        CFG_MAX_LENGTH:  cfg.max_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rx.ready = !out_valid || res.ready;
  assign step     = rx.valid && rx.ready;

  cpd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (rx.rx_byte),
    .cfg     (cfg),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx.ready) begin
      out_valid <= step && step_res.valid;
    end
  end

  // payload loads on every transfer that makes a result
  always_ff @(posedge clk) begin
    if (step && step_res.valid) begin
      out_kind          <= step_res.kind;
      out_payload_byte  <= step_res.payload_byte;
      out_byte_index    <= step_res.byte_index;
      out_msg_id        <= step_res.msg_id;
      out_packet_length <= step_res.packet_length;
    end
  end

  assign res.valid         = out_valid;
  assign res.kind          = out_kind;
  assign res.payload_byte  = out_payload_byte;
  assign res.byte_index    = out_byte_index;
  assign res.msg_id        = out_msg_id;
  assign res.packet_length = out_packet_length;

  `CPD_ASSERT_IMPL(a_no_overwrite, clk, rst, out_valid && !res.ready, !rx.ready, "byte taken while result stalled")
  `CPD_ASSERT_IMPL(a_index_in_frame, clk, rst, out_valid && out_kind == KIND_PAYLOAD, out_byte_index < out_packet_length, "payload index beyond length")
  `CPD_ASSERT_IMPL(a_status_clean, clk, rst, out_valid && out_kind != KIND_PAYLOAD, out_payload_byte == 8'd0 && out_byte_index == 16'd0, "status result carries payload")
  `CPD_ASSERT_NEXT(a_result_follows, clk, rst, step && step_res.valid, out_valid, "result lost")

endmodule
